// ===== src/trigger_road_match_tally_assert.svh =====
// Assertion shorthands shared by the road-match tally modules.
// Both expect clk_i and rst_ni in scope.
`ifndef TRIGGER_ROAD_MATCH_TALLY_ASSERT_SVH
`define TRIGGER_ROAD_MATCH_TALLY_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TRM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/trm_pkg.sv =====
`default_nettype none

package trm_pkg;

  localparam int unsigned TABLES      = 4;
  localparam int unsigned TBL_W       = 2;
  localparam int unsigned CFG_W       = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned ROAD_W      = 16;
  localparam int unsigned TALLY_W     = 32;
  localparam int unsigned IN_ELEM_W   = 8;
  localparam int unsigned IDX_IN_W    = 8;
  localparam int unsigned COUNT_OUT_W = 9;

  localparam logic [TALLY_W-1:0] TALLY_MAX   = '1;
  localparam logic [ROAD_W-1:0]  NO_MATCH_ID = '1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // Controller to datapath.
  typedef struct packed {
    logic clr_en;
    logic load;
    logic start_event;
    logic start_read;
    logic scan_en;
    logic rd_issue;
    logic rd_capture;
    logic emit;
  } trm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic scan_done;
  } trm_sts_t;

endpackage

`default_nettype wire

// ===== src/trm_ram.sv =====
`default_nettype none

module trm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/trm_ctrl.sv =====
`default_nettype none

module trm_ctrl
  import trm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [1:0] action_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output trm_cmd_t      cmd_o,
  input  wire trm_sts_t sts_i
);

  `include "trigger_road_match_tally_assert.svh"

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.clr_en      = (state_q == ST_CLEAR);
    cmd_o.load        = accept && (action_i == ACT_LOAD);
    cmd_o.start_event = accept && (action_i == ACT_EVENT);
    cmd_o.start_read  = accept && (action_i == ACT_READ);
    cmd_o.scan_en     = (state_q == ST_SCAN);
    cmd_o.rd_issue    = (state_q == ST_RD_ADDR);
    cmd_o.rd_capture  = (state_q == ST_RD_DATA);
    cmd_o.emit        = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_EVENT: state_d = ST_SCAN;
            ACT_READ:  state_d = ST_RD_ADDR;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_EMIT;
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: state_d = ST_EMIT;
      ST_EMIT: begin
        if (cmd_o.emit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TRM_ASSERT(a_emit_returns, cmd_o.emit |=> in_ready_o && out_valid_q, "no result posted")
  `TRM_ASSERT(a_scan_ends, cmd_o.scan_en && sts_i.scan_done |=> state_q == ST_EMIT, "scan end missed")
  `TRM_ASSERT_NEVER(a_no_drop, out_valid_q && !out_ready_i && cmd_o.emit, "result overwritten")

endmodule

`default_nettype wire

// ===== src/trm_dp.sv =====
`default_nettype none

module trm_dp
  import trm_pkg::*;
#(
  parameter int unsigned ROADS_PER_TABLE = 256,
  parameter int unsigned ELEMENT_BITS    = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire trm_cmd_t                    cmd_i,
  output trm_sts_t                         sts_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [CFG_W-1:0]            cfg_data_i,
  input  wire logic                        charge_positive_i,
  input  wire logic                        detector_half_i,
  input  wire logic [IDX_IN_W-1:0]         entry_index_i,
  input  wire logic signed [ROAD_W-1:0]    load_road_id_i,
  input  wire logic [IN_ELEM_W-1:0]        element_one_i,
  input  wire logic [IN_ELEM_W-1:0]        element_two_i,
  input  wire logic [IN_ELEM_W-1:0]        element_three_i,
  input  wire logic [IN_ELEM_W-1:0]        element_four_i,
  input  wire logic                        trigger_accepted_i,
  output logic [COUNT_OUT_W-1:0]           match_count_o,
  output logic signed [ROAD_W-1:0]         road_id_out_o,
  output logic [TALLY_W-1:0]               total_tally_o,
  output logic [TALLY_W-1:0]               accept_tally_o,
  output logic                             is_read_reply_o
);

  `include "trigger_road_match_tally_assert.svh"

  localparam int unsigned IW      = (ROADS_PER_TABLE > 1) ? $clog2(ROADS_PER_TABLE) : 1;
  localparam int unsigned AW      = IW + TBL_W;
  localparam int unsigned DEPTH   = 1 << AW;
  localparam int unsigned NW      = $clog2(ROADS_PER_TABLE + 1);
  localparam int unsigned CMPW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int unsigned XW      = (IW > IDX_IN_W) ? IW : IDX_IN_W;
  localparam int unsigned EXW     = (ELEMENT_BITS > IN_ELEM_W) ? ELEMENT_BITS : IN_ELEM_W;
  localparam int unsigned ELEMS_W = 4 * ELEMENT_BITS;
  localparam int unsigned ENTRY_W = ROAD_W + ELEMS_W;
  localparam int unsigned PAIR_W  = 2 * TALLY_W;

  function automatic logic [ELEMENT_BITS-1:0] elem_fit(input logic [IN_ELEM_W-1:0] e);
    logic [EXW-1:0] w;
    w = EXW'(e);
    return w[ELEMENT_BITS-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_fit(input logic [IDX_IN_W-1:0] idx);
    logic [XW-1:0] w;
    w = XW'(idx);
    return w[IW-1:0];
  endfunction

  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    return (v == TALLY_MAX) ? v : v + TALLY_W'(1);
  endfunction

  // Configuration: active entry count per table.
  logic [CFG_W-1:0] cfg_q [TABLES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLES; t++) cfg_q[t] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Item fields and scan state.
  logic [TBL_W-1:0]        tbl_in;
  logic                    idx_ok_in;
  logic [ELEMS_W-1:0]      elems_in;
  logic [CMPW-1:0]         cfg_sel;
  logic [NW-1:0]           n_start;

  logic [TBL_W-1:0]        tbl_q;
  logic [IDX_IN_W-1:0]     idx_q;
  logic                    idx_ok_q;
  logic [ELEMS_W-1:0]      elems_q;
  logic                    flag_q;
  logic                    is_rd_q;
  logic [NW-1:0]           n_q;
  logic [NW-1:0]           scan_q;
  logic                    pend_q;
  logic [AW-1:0]           paddr_q;
  logic [NW-1:0]           match_q;
  logic [ROAD_W-1:0]       last_q;
  logic [TALLY_W-1:0]      tot_q;
  logic [TALLY_W-1:0]      acc_q;
  logic [AW-1:0]           clr_q;

  assign tbl_in    = {charge_positive_i, detector_half_i};
  assign idx_ok_in = (32'(entry_index_i) < 32'(ROADS_PER_TABLE));
  assign elems_in  = {elem_fit(element_one_i), elem_fit(element_two_i),
                      elem_fit(element_three_i), elem_fit(element_four_i)};
  assign cfg_sel   = CMPW'(cfg_q[tbl_in]);
  assign n_start   = (cfg_sel > CMPW'(ROADS_PER_TABLE)) ? NW'(ROADS_PER_TABLE) : NW'(cfg_sel);

  // Memories.
  logic               road_we;
  logic [AW-1:0]      road_waddr;
  logic [ENTRY_W-1:0] road_wdata;
  logic [ENTRY_W-1:0] road_rdata;
  logic               tally_we;
  logic [AW-1:0]      tally_waddr;
  logic [PAIR_W-1:0]  tally_wdata;
  logic [PAIR_W-1:0]  tally_rdata;
  logic [AW-1:0]      raddr;
  logic               issue;
  logic               hit;
  logic [TALLY_W-1:0] rd_tot;
  logic [TALLY_W-1:0] rd_acc;

  assign road_we    = cmd_i.load && idx_ok_in;
  assign road_waddr = {tbl_in, idx_fit(entry_index_i)};
  assign road_wdata = {load_road_id_i, elems_in};

  assign raddr  = cmd_i.rd_issue ? {tbl_q, idx_fit(idx_q)} : {tbl_q, scan_q[IW-1:0]};
  assign issue  = cmd_i.scan_en && (scan_q != n_q);
  assign hit    = pend_q && (road_rdata[ELEMS_W-1:0] == elems_q);
  assign rd_tot = tally_rdata[PAIR_W-1:TALLY_W];
  assign rd_acc = tally_rdata[TALLY_W-1:0];

  always_comb begin
    tally_we    = 1'b0;
    tally_waddr = paddr_q;
    tally_wdata = {sat_inc(rd_tot), flag_q ? sat_inc(rd_acc) : rd_acc};
    if (cmd_i.clr_en) begin
      tally_we    = 1'b1;
      tally_waddr = clr_q;
      tally_wdata = '0;
    end else if (hit) begin
      tally_we = 1'b1;
    end
  end

  trm_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_road_ram (
    .clk_i   (clk_i),
    .we_i    (road_we),
    .waddr_i (road_waddr),
    .wdata_i (road_wdata),
    .raddr_i (raddr),
    .rdata_o (road_rdata)
  );

  trm_ram #(.WIDTH(PAIR_W), .DEPTH(DEPTH)) u_tally_ram (
    .clk_i   (clk_i),
    .we_i    (tally_we),
    .waddr_i (tally_waddr),
    .wdata_i (tally_wdata),
    .raddr_i (raddr),
    .rdata_o (tally_rdata)
  );

  assign sts_o.clr_last  = &clr_q;
  assign sts_o.scan_done = (scan_q == n_q) && !pend_q;

  // Control-side registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      pend_q  <= 1'b0;
      scan_q  <= '0;
      n_q     <= '0;
      match_q <= '0;
    end else begin
      if (cmd_i.clr_en) clr_q <= clr_q + AW'(1);
      if (cmd_i.start_event || cmd_i.start_read) begin
        pend_q  <= 1'b0;
        scan_q  <= '0;
        n_q     <= n_start;
        match_q <= '0;
      end else if (cmd_i.scan_en) begin
        pend_q <= issue;
        if (issue) scan_q <= scan_q + NW'(1);
        if (hit) match_q <= match_q + NW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_event || cmd_i.start_read) begin
      tbl_q    <= tbl_in;
      idx_q    <= entry_index_i;
      idx_ok_q <= idx_ok_in;
      elems_q  <= elems_in;
      flag_q   <= trigger_accepted_i;
      is_rd_q  <= cmd_i.start_read;
      last_q   <= NO_MATCH_ID;
      tot_q    <= '0;
      acc_q    <= '0;
    end else if (cmd_i.rd_capture) begin
      last_q <= idx_ok_q ? road_rdata[ENTRY_W-1:ELEMS_W] : '0;
      tot_q  <= idx_ok_q ? rd_tot : '0;
      acc_q  <= idx_ok_q ? rd_acc : '0;
    end else if (hit) begin
      last_q <= road_rdata[ENTRY_W-1:ELEMS_W];
    end
    if (issue) paddr_q <= raddr;
    if (cmd_i.emit) begin
      match_count_o   <= COUNT_OUT_W'(match_q);
      road_id_out_o   <= last_q;
      total_tally_o   <= tot_q;
      accept_tally_o  <= acc_q;
      is_read_reply_o <= is_rd_q;
    end
  end

  `TRM_ASSERT(a_match_bound, match_q <= n_q, "match count beyond active entries")
  `TRM_ASSERT(a_pend_after_issue, pend_q |-> scan_q != '0, "compare without an issued read")
  `TRM_ASSERT_NEVER(a_scan_overrun, scan_q > n_q, "scan ran past active entries")

endmodule

`default_nettype wire

// ===== src/trigger_road_match_tally.sv =====
// Channel  Handshake                  Payload
// -------  -------------------------  -------------------------------------------------
// in       in_valid_i / in_ready_o    action, charge, half, index, road id, 4 elements, flag
// out      out_valid_o / out_ready_i  match_count, road_id_out, tallies, is_read_reply
// cfg      cfg_we_i (no wait)         cfg_idx_i selects one of four active-entry counts
//
// A load completes on its transfer; a read steps through its address and data states
// and then posts its result. An event scans the table's n active entries, with
// n the table's active entry count clamped to the table size: the scan reads one
// entry per cycle from the road and tally memories and then posts its result.
// Once the result is posted, the controller is idle again and takes the next item.
// After reset a clearing pass zeroes the whole tally memory; no item is taken until it ends.
// The next item is taken while a posted result waits; a new result holds in the
// controller until the output register frees up.
`default_nettype none

module trigger_road_match_tally
  import trm_pkg::*;
#(
  parameter int unsigned ROADS_PER_TABLE = 256,
  parameter int unsigned ELEMENT_BITS    = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               action_i,
  input  wire logic                     charge_positive_i,
  input  wire logic                     detector_half_i,
  input  wire logic [IDX_IN_W-1:0]      entry_index_i,
  input  wire logic signed [ROAD_W-1:0] load_road_id_i,
  input  wire logic [IN_ELEM_W-1:0]     element_one_i,
  input  wire logic [IN_ELEM_W-1:0]     element_two_i,
  input  wire logic [IN_ELEM_W-1:0]     element_three_i,
  input  wire logic [IN_ELEM_W-1:0]     element_four_i,
  input  wire logic                     trigger_accepted_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [COUNT_OUT_W-1:0]        match_count_o,
  output logic signed [ROAD_W-1:0]      road_id_out_o,
  output logic [TALLY_W-1:0]            total_tally_o,
  output logic [TALLY_W-1:0]            accept_tally_o,
  output logic                          is_read_reply_o
);

  // Command and status between sequencer and datapath.
  trm_cmd_t cmd;
  trm_sts_t sts;

  // Sequence the clearing pass, the per-item steps and the result transfer.
  trm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Hold the road and tally memories, the scan pipeline and the result register.
  trm_dp #(
    .ROADS_PER_TABLE (ROADS_PER_TABLE),
    .ELEMENT_BITS    (ELEMENT_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .charge_positive_i  (charge_positive_i),
    .detector_half_i    (detector_half_i),
    .entry_index_i      (entry_index_i),
    .load_road_id_i     (load_road_id_i),
    .element_one_i      (element_one_i),
    .element_two_i      (element_two_i),
    .element_three_i    (element_three_i),
    .element_four_i     (element_four_i),
    .trigger_accepted_i (trigger_accepted_i),
    .match_count_o      (match_count_o),
    .road_id_out_o      (road_id_out_o),
    .total_tally_o      (total_tally_o),
    .accept_tally_o     (accept_tally_o),
    .is_read_reply_o    (is_read_reply_o)
  );

endmodule

`default_nettype wire
